@@ hw/rtl/etc1_pkg.sv @@
// etc1 block decoder package: decoded block record, modifier codebook,
// and the channel clamp used by the back module.
// no dependencies.
`default_nettype none

package etc1_pkg;

  localparam int unsigned QueueDepth = 2;

  // one block after header decode, ready for pixel emission
  typedef struct packed {
    logic [23:0] base1;  // widened first base color, r g b
    logic [23:0] base2;  // widened second base color, r g b
    logic [2:0]  cw1;    // table codeword of first subblock
    logic [2:0]  cw2;    // table codeword of second subblock
    logic        flip;
    logic [31:0] idx;    // pixel index word
  } etc1_block_t;

  localparam logic signed [8:0] ModTable [8][4] = '{
    '{ 9'sd2,  9'sd8,   -9'sd2,  -9'sd8   },
    '{ 9'sd5,  9'sd17,  -9'sd5,  -9'sd17  },
    '{ 9'sd9,  9'sd29,  -9'sd9,  -9'sd29  },
    '{ 9'sd13, 9'sd42,  -9'sd13, -9'sd42  },
    '{ 9'sd18, 9'sd60,  -9'sd18, -9'sd60  },
    '{ 9'sd24, 9'sd80,  -9'sd24, -9'sd80  },
    '{ 9'sd33, 9'sd106, -9'sd33, -9'sd106 },
    '{ 9'sd47, 9'sd183, -9'sd47, -9'sd183 }
  };

  function automatic logic signed [8:0] etc1_modifier(input logic [2:0] cw,
                                                     input logic [1:0] sel);
    return ModTable[cw][sel];
  endfunction

  // sum range is -183..438, so bit 9 is the sign and bit 8 flags overflow
  function automatic logic [7:0] etc1_clamp(input logic signed [9:0] v);
    logic [7:0] r;
    if (v[9]) begin
      r = 8'd0;
    end else if (v[8]) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/etc1_front.sv @@
// etc1 front end: accepts block words, decodes header into base colors,
// codewords and flip, and registers the decoded block. uses etc1_pkg.
`default_nettype none

module etc1_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [63:0]        block_word_i,
  output logic                    dec_valid_o,
  input  wire logic               dec_ready_i,
  output etc1_pkg::etc1_block_t   dec_o
);
  import etc1_pkg::*;

  logic [31:0]  hi;
  logic         diff;
  logic [23:0]  c1;
  logic [23:0]  c2;
  etc1_block_t  dec_d;
  etc1_block_t  dec_q;
  logic         valid_d;
  logic         valid_q;

  assign hi   = block_word_i[63:32];
  assign diff = hi[1];

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic [7:0] chan_byte;
    logic [4:0] sum;
    assign chan_byte = hi[31-8*ch -: 8];
    // signed delta added modulo 32
    assign sum = chan_byte[7:3] + {{2{chan_byte[2]}}, chan_byte[2:0]};
    assign c1[23-8*ch -: 8] = diff ? {chan_byte[7:3], chan_byte[7:5]}
                                   : {chan_byte[7:4], chan_byte[7:4]};
    assign c2[23-8*ch -: 8] = diff ? {sum, sum[4:2]}
                                   : {chan_byte[3:0], chan_byte[3:0]};
  end

  always_comb begin
    dec_d.base1 = c1;
    dec_d.base2 = c2;
    dec_d.cw1   = hi[7:5];
    dec_d.cw2   = hi[4:2];
    dec_d.flip  = hi[0];
    dec_d.idx   = block_word_i[31:0];
  end

  assign in_ready_o = !valid_q || dec_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (dec_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      dec_q <= dec_d;
    end
  end

  assign dec_valid_o = valid_q;
  assign dec_o       = dec_q;

endmodule

`default_nettype wire

@@ hw/rtl/etc1_queue.sv @@
// etc1 block queue: small fifo of decoded blocks between front and back.
// uses etc1_pkg.
`default_nettype none

module etc1_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  wr_valid_i,
  output logic                       wr_ready_o,
  input  wire etc1_pkg::etc1_block_t wr_data_i,
  output logic                       rd_valid_o,
  input  wire logic                  rd_ready_i,
  output etc1_pkg::etc1_block_t      rd_data_o
);
  import etc1_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  etc1_block_t          entries_q [QueueDepth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 push;
  logic                 pop;

  assign wr_ready_o = (count_q != CntW'(QueueDepth));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/etc1_back.sv @@
// etc1 back end: walks the 16 pixels of one decoded block, one per cycle
// unless the output stalls, into a registered output word. uses etc1_pkg.
`default_nettype none

module etc1_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  blk_valid_i,
  output logic                       blk_ready_o,
  input  wire etc1_pkg::etc1_block_t blk_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [7:0]                 red_o,
  output logic [7:0]                 green_o,
  output logic [7:0]                 blue_o,
  output logic [1:0]                 pixel_row_o,
  output logic [1:0]                 pixel_col_o,
  output logic                       last_pixel_o
);
  import etc1_pkg::*;

  etc1_block_t        cur_q;
  logic               busy_q, busy_d;
  logic [3:0]         cnt_q, cnt_d;
  logic               ovalid_q, ovalid_d;
  logic               fire;
  logic               last;
  logic               load;
  logic [1:0]         x;
  logic [1:0]         y;
  logic [3:0]         p;
  logic [1:0]         sel;
  logic               first;
  logic [23:0]        color;
  logic [2:0]         cw;
  logic signed [8:0]  modv;
  logic [7:0]         pix_r, pix_g, pix_b;

  assign fire        = busy_q && (!ovalid_q || out_ready_i);
  assign last        = (cnt_q == 4'd15);
  assign blk_ready_o = !busy_q || (fire && last);
  assign load        = blk_valid_i && blk_ready_o;

  // row-major walk; index bit position is 4*x + y
  assign y     = cnt_q[3:2];
  assign x     = cnt_q[1:0];
  assign p     = {x, y};
  assign sel   = {cur_q.idx[{1'b1, p}], cur_q.idx[{1'b0, p}]};
  assign first = cur_q.flip ? !y[1] : !x[1];
  assign color = first ? cur_q.base1 : cur_q.base2;
  assign cw    = first ? cur_q.cw1 : cur_q.cw2;
  assign modv  = etc1_modifier(cw, sel);

  assign pix_r = etc1_clamp($signed({2'b00, color[23:16]}) + 10'(modv));
  assign pix_g = etc1_clamp($signed({2'b00, color[15:8]})  + 10'(modv));
  assign pix_b = etc1_clamp($signed({2'b00, color[7:0]})   + 10'(modv));

  always_comb begin
    busy_d   = busy_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q;
    if (fire) begin
      cnt_d    = cnt_q + 4'd1;
      ovalid_d = 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= 4'd0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= blk_i;
    end
    if (fire) begin
      red_o        <= pix_r;
      green_o      <= pix_g;
      blue_o       <= pix_b;
      pixel_row_o  <= y;
      pixel_col_o  <= x;
      last_pixel_o <= last;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

`default_nettype wire

@@ hw/rtl/etc1_block_decoder.sv @@
// etc1 block decoder top level: front decode, block queue, pixel emitter.
// uses etc1_pkg, etc1_front, etc1_queue, etc1_back.
`default_nettype none

// Decodes one 64-bit ETC1 block (header word in bits 63:32, index word in
// 31:0) into sixteen RGB888 pixels, row 0 columns 0..3 first, each tagged
// with its row and column and with last_pixel_o on the sixteenth. The pixel
// emitter produces one pixel per cycle while the output is not stalled, and
// that emitter is the rate-setting unit. A block passes the header decode
// register, a queue entry, the emitter's block register and the output
// register on its way to the first output. The header decoder and a two
// block queue sit in front of the emitter, so new blocks are still accepted
// while pixels are stalled at the output, until the queue and front fill.

module etc1_block_decoder (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [63:0]  block_word_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic [1:0]        pixel_row_o,
  output logic [1:0]        pixel_col_o,
  output logic              last_pixel_o
);
  import etc1_pkg::*;

  etc1_block_t  dec;
  logic         dec_valid;
  logic         dec_ready;
  etc1_block_t  blk;
  logic         blk_valid;
  logic         blk_ready;

  etc1_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .block_word_i (block_word_i),
    .dec_valid_o  (dec_valid),
    .dec_ready_i  (dec_ready),
    .dec_o        (dec)
  );

  etc1_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (dec_valid),
    .wr_ready_o (dec_ready),
    .wr_data_i  (dec),
    .rd_valid_o (blk_valid),
    .rd_ready_i (blk_ready),
    .rd_data_o  (blk)
  );

  etc1_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .blk_valid_i  (blk_valid),
    .blk_ready_o  (blk_ready),
    .blk_i        (blk),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .pixel_row_o  (pixel_row_o),
    .pixel_col_o  (pixel_col_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/etc1_checker.sv @@
// etc1 port checker: pixel order and output handshake properties seen on
// the top level ports, bound to etc1_block_decoder.
`default_nettype none

module etc1_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  red_o,
  input wire logic [7:0]  green_o,
  input wire logic [7:0]  blue_o,
  input wire logic [1:0]  pixel_row_o,
  input wire logic [1:0]  pixel_col_o,
  input wire logic        last_pixel_o
);

  logic out_fire;
  assign out_fire = out_valid_o && out_ready_i;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o
      && $stable({red_o, green_o, blue_o, pixel_row_o, pixel_col_o, last_pixel_o}))
    else $error("output word changed while stalled");

  // last flag only on the bottom right pixel
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (last_pixel_o == (pixel_row_o == 2'd3 && pixel_col_o == 2'd3)))
    else $error("last pixel flag does not match pixel position");

  // mid-block pixels follow without a gap
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !last_pixel_o |=> out_valid_o)
    else $error("gap inside a block");

  // row-major order
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !last_pixel_o |=>
      ({pixel_row_o, pixel_col_o} == $past({pixel_row_o, pixel_col_o}) + 4'd1))
    else $error("pixel out of row-major order");

endmodule

bind etc1_block_decoder etc1_checker u_etc1_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .red_o        (red_o),
  .green_o      (green_o),
  .blue_o       (blue_o),
  .pixel_row_o  (pixel_row_o),
  .pixel_col_o  (pixel_col_o),
  .last_pixel_o (last_pixel_o)
);

`default_nettype wire
